// ===== sv/msp_pkg.sv =====
// ---------------------------------------------------------------------------
// msp_pkg: shared types and constants of the motor speed loop
// Field widths, register indexes, reset values and the band decision type.
// ---------------------------------------------------------------------------
package msp_pkg;

	// field and register widths
	localparam int unsigned PULSE_W  = 16;
	localparam int unsigned TARGET_W = 11;
	localparam int unsigned GAIN_W   = 16;
	localparam int unsigned LIMIT_W  = 15;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned IDX_W    = 3;

	// internal widths
	localparam int unsigned ERR_W  = 18;   // wheel target minus filtered speed
	localparam int unsigned DERR_W = 19;   // change of the error
	localparam int unsigned PP_W   = 35;   // Kp * error
	localparam int unsigned PD_W   = 36;   // Kd * error change
	localparam int unsigned ACC_W  = 25;   // Q.8 accumulator, within +/- limit*256

	// register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_KP_FAST     = 3'd0,
		REG_KD_FAST     = 3'd1,
		REG_KP_SLOW     = 3'd2,
		REG_KD_SLOW     = 3'd3,
		REG_SPEED_SPLIT = 3'd4,
		REG_ERR_HIGH    = 3'd5,
		REG_ERR_LOW     = 3'd6,
		REG_PWM_LIMIT   = 3'd7
	} cfg_reg_t;

	// register reset values
	localparam logic [GAIN_W-1:0]         KP_FAST_RST     = 16'd461;
	localparam logic [GAIN_W-1:0]         KD_FAST_RST     = 16'd6656;
	localparam logic [GAIN_W-1:0]         KP_SLOW_RST     = 16'd205;
	localparam logic [GAIN_W-1:0]         KD_SLOW_RST     = 16'd5120;
	localparam logic signed [PULSE_W-1:0] SPEED_SPLIT_RST = 16'sd850;
	localparam logic [LIMIT_W-1:0]        ERR_HIGH_RST    = 15'd400;
	localparam logic signed [PULSE_W-1:0] ERR_LOW_RST     = -16'sd300;
	localparam logic [LIMIT_W-1:0]        PWM_LIMIT_RST   = 15'd9000;

	// where the error sits relative to the band
	typedef struct packed {
		logic in_band;    // err_low < err < err_high
		logic at_high;    // err >= err_high
	} band_t;

endpackage

// ===== sv/msp_in_if.sv =====
// ---------------------------------------------------------------------------
// msp_in_if: measurement channel
// One beat carries the raw encoder count and the two targets.
// ---------------------------------------------------------------------------
interface msp_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [msp_pkg::PULSE_W-1:0]     raw_pulse;
	logic        [msp_pkg::TARGET_W-1:0]    motor_target;
	logic signed [msp_pkg::PULSE_W-1:0]     car_target;

	modport source (output valid, output raw_pulse, output motor_target,
		output car_target, input ready);
	modport sink (input valid, input raw_pulse, input motor_target,
		input car_target, output ready);
endinterface

// ===== sv/msp_out_if.sv =====
// ---------------------------------------------------------------------------
// msp_out_if: drive result channel
// One beat carries the drive value, both duties and the filtered speed.
// ---------------------------------------------------------------------------
interface msp_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [msp_pkg::PULSE_W-1:0]     drive_value;
	logic        [msp_pkg::LIMIT_W-1:0]     forward_duty;
	logic        [msp_pkg::LIMIT_W-1:0]     reverse_duty;
	logic signed [msp_pkg::PULSE_W-1:0]     filtered_speed;

	modport source (output valid, output drive_value, output forward_duty,
		output reverse_duty, output filtered_speed, input ready);
	modport sink (input valid, input drive_value, input forward_duty,
		input reverse_duty, input filtered_speed, output ready);
endinterface

// ===== sv/msp_acc_update.sv =====
// ---------------------------------------------------------------------------
// msp_acc_update: accumulator next value
// Adds the PD increment inside the band, forces +/- limit outside it,
// then clamps to the limit.
// ---------------------------------------------------------------------------
module msp_acc_update (
	input  logic signed [msp_pkg::ACC_W-1:0]   acc,
	input  logic signed [msp_pkg::PP_W-1:0]    pp,
	input  logic signed [msp_pkg::PD_W-1:0]    pd,
	input  msp_pkg::band_t                     band,
	input  logic        [msp_pkg::LIMIT_W-1:0] pwm_limit,
	output logic signed [msp_pkg::ACC_W-1:0]   acc_next
);

	localparam int unsigned SUM_W = msp_pkg::PD_W + 1;

	logic signed [msp_pkg::ACC_W-1:0] lim;
	logic signed [SUM_W-1:0]          lim_x;
	logic signed [SUM_W-1:0]          sum;

	// limit in Q.8
	assign lim   = $signed({2'b00, pwm_limit, 8'h00});
	assign lim_x = {{(SUM_W-msp_pkg::ACC_W){lim[msp_pkg::ACC_W-1]}}, lim};

	// exact sum, wide enough that nothing wraps
	assign sum = {{(SUM_W-msp_pkg::ACC_W){acc[msp_pkg::ACC_W-1]}}, acc}
		+ {{(SUM_W-msp_pkg::PP_W){pp[msp_pkg::PP_W-1]}}, pp}
		+ {pd[msp_pkg::PD_W-1], pd};

	// bang-bang outside the band, clamped PD step inside
	always_comb begin
		priority if (!band.in_band && band.at_high) begin
			acc_next = lim;
		end else if (!band.in_band) begin
			acc_next = -lim;
		end else if (sum > lim_x) begin
			acc_next = lim;
		end else if (sum < -lim_x) begin
			acc_next = -lim;
		end else begin
			acc_next = sum[msp_pkg::ACC_W-1:0];
		end
	end

endmodule

// ===== sv/motor_speed_pd_bang_bang_core.sv =====
// ---------------------------------------------------------------------------
// motor_speed_pd_bang_bang_core: speed loop for one motor
// Low-pass speed filter, incremental PD on a Q.8 accumulator with two gain
// pairs, bang-bang outside the error band, clamped drive and duty split.
// ---------------------------------------------------------------------------
// The block takes one measurement beat per clock while results are taken
// and gives one result beat for each, through the stages filter, error and
// gain select, the two gain products, the accumulator update, and the output
// register. The filter state, the last error and the accumulator each close
// their loop within a single stage, so a new beat can follow every cycle
// while results are taken. Each stage holds its beat while the one after it
// is full and cannot move on, so a waiting result does not stop earlier
// stages from filling. Registers are written through cfg_wr_en/cfg_index/cfg_data;
// the user must do so only while no beat is in flight; the block does not enforce it.
module motor_speed_pd_bang_bang_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [msp_pkg::IDX_W-1:0]          cfg_index,
	input  logic [msp_pkg::CFG_W-1:0]          cfg_data,
	msp_in_if.sink                             item,
	msp_out_if.source                          result
);

	localparam int unsigned SUM3_W = msp_pkg::PULSE_W + 3;

	// configuration registers
	logic        [msp_pkg::GAIN_W-1:0]  kp_fast_q, kd_fast_q, kp_slow_q, kd_slow_q;
	logic signed [msp_pkg::PULSE_W-1:0] speed_split_q;
	logic        [msp_pkg::LIMIT_W-1:0] err_high_q;
	logic signed [msp_pkg::PULSE_W-1:0] err_low_q;
	logic        [msp_pkg::LIMIT_W-1:0] pwm_limit_q;

	// loop state
	logic signed [msp_pkg::PULSE_W-1:0] est_q;
	logic signed [msp_pkg::ERR_W-1:0]   prev_err_q;
	logic signed [msp_pkg::ACC_W-1:0]   acc_q;

	// stage valids and moves
	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic adv1, adv2, adv3, adv4, adv5;

	// stage payloads
	logic        [msp_pkg::TARGET_W-1:0] target_s1;
	logic signed [msp_pkg::PULSE_W-1:0]  car_s1;
	logic signed [msp_pkg::ERR_W-1:0]    err_s2;
	logic signed [msp_pkg::DERR_W-1:0]   derr_s2;
	logic        [msp_pkg::GAIN_W-1:0]   kp_s2, kd_s2;
	msp_pkg::band_t                      band_s2, band_s3;
	logic signed [msp_pkg::PULSE_W-1:0]  est_s2, est_s3, est_s4, est_s5;
	logic signed [msp_pkg::PP_W-1:0]     pp_s3;
	logic signed [msp_pkg::PD_W-1:0]     pd_s3;
	logic signed [msp_pkg::PULSE_W-1:0]  drive_s5;
	logic        [msp_pkg::LIMIT_W-1:0]  fwd_s5, rev_s5;

	// combinational
	logic signed [SUM3_W-1:0]            est_x, raw_x, sum3, sum3_r;
	logic signed [msp_pkg::PULSE_W-1:0]  est_next;
	logic signed [msp_pkg::ERR_W-1:0]    err;
	logic signed [msp_pkg::DERR_W-1:0]   derr;
	logic signed [msp_pkg::ERR_W-1:0]    err_high_x, err_low_x;
	msp_pkg::band_t                      band;
	logic                                fast;
	logic signed [msp_pkg::ACC_W-1:0]    acc_next;
	logic signed [msp_pkg::ACC_W-1:0]    acc_r;
	logic signed [msp_pkg::PULSE_W:0]    drive_x;
	logic signed [msp_pkg::ACC_W-1:0]    lim_chk;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_fast_q     <= msp_pkg::KP_FAST_RST;
			kd_fast_q     <= msp_pkg::KD_FAST_RST;
			kp_slow_q     <= msp_pkg::KP_SLOW_RST;
			kd_slow_q     <= msp_pkg::KD_SLOW_RST;
			speed_split_q <= msp_pkg::SPEED_SPLIT_RST;
			err_high_q    <= msp_pkg::ERR_HIGH_RST;
			err_low_q     <= msp_pkg::ERR_LOW_RST;
			pwm_limit_q   <= msp_pkg::PWM_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (msp_pkg::cfg_reg_t'(cfg_index))
				msp_pkg::REG_KP_FAST:     kp_fast_q     <= cfg_data;
				msp_pkg::REG_KD_FAST:     kd_fast_q     <= cfg_data;
				msp_pkg::REG_KP_SLOW:     kp_slow_q     <= cfg_data;
				msp_pkg::REG_KD_SLOW:     kd_slow_q     <= cfg_data;
				msp_pkg::REG_SPEED_SPLIT: speed_split_q <= $signed(cfg_data);
				msp_pkg::REG_ERR_HIGH:    err_high_q    <= cfg_data[msp_pkg::LIMIT_W-1:0];
				msp_pkg::REG_ERR_LOW:     err_low_q     <= $signed(cfg_data);
				msp_pkg::REG_PWM_LIMIT:   pwm_limit_q   <= cfg_data[msp_pkg::LIMIT_W-1:0];
			endcase
		end
	end

	// ready chain: a stage takes a beat when empty or when its beat moves on
	assign rdy5 = !v5_q || result.ready;
	assign rdy4 = !v4_q || rdy5;
	assign rdy3 = !v3_q || rdy4;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;
	assign item.ready = rdy1;

	assign adv1 = item.valid && rdy1;
	assign adv2 = v1_q && rdy2;
	assign adv3 = v2_q && rdy3;
	assign adv4 = v3_q && rdy4;
	assign adv5 = v4_q && rdy5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= item.valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= v3_q;
			if (rdy5) v5_q <= v4_q;
		end
	end

	// filter: (3*old + raw)/4, truncated toward zero
	assign est_x    = {{3{est_q[msp_pkg::PULSE_W-1]}}, est_q};
	assign raw_x    = {{3{item.raw_pulse[msp_pkg::PULSE_W-1]}}, item.raw_pulse};
	assign sum3     = (est_x <<< 1) + est_x + raw_x;
	assign sum3_r   = sum3 + (sum3[SUM3_W-1] ? SUM3_W'(3) : SUM3_W'(0));
	assign est_next = sum3_r[msp_pkg::PULSE_W+1:2];

	// error, error change, band and gain pair
	assign err  = $signed({{(msp_pkg::ERR_W-msp_pkg::TARGET_W){1'b0}}, target_s1})
		- $signed({{(msp_pkg::ERR_W-msp_pkg::PULSE_W){est_q[msp_pkg::PULSE_W-1]}}, est_q});
	assign derr = {err[msp_pkg::ERR_W-1], err} - {prev_err_q[msp_pkg::ERR_W-1], prev_err_q};
	assign err_high_x   = $signed({{(msp_pkg::ERR_W-msp_pkg::LIMIT_W){1'b0}}, err_high_q});
	assign err_low_x    = {{(msp_pkg::ERR_W-msp_pkg::PULSE_W){err_low_q[msp_pkg::PULSE_W-1]}},
		err_low_q};
	assign band = '{in_band: (err < err_high_x) && (err > err_low_x),
		at_high: (err >= err_high_x)};
	assign fast         = car_s1 > speed_split_q;

	// accumulator step
	msp_acc_update u_acc (
		.acc       (acc_q),
		.pp        (pp_s3),
		.pd        (pd_s3),
		.band      (band_s3),
		.pwm_limit (pwm_limit_q),
		.acc_next  (acc_next)
	);

	// drive = acc/256 truncated toward zero
	assign acc_r   = acc_q + (acc_q[msp_pkg::ACC_W-1] ? msp_pkg::ACC_W'(255) : '0);
	assign drive_x = acc_r[msp_pkg::ACC_W-1:8];

	// loop state, updated as a beat enters the stage that owns it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q      <= '0;
			prev_err_q <= '0;
			acc_q      <= '0;
		end else begin
			if (adv1) est_q      <= est_next;
			if (adv2) prev_err_q <= err;
			if (adv4) acc_q      <= acc_next;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv1) begin
			target_s1 <= item.motor_target;
			car_s1    <= item.car_target;
		end
		if (adv2) begin
			err_s2  <= err;
			derr_s2 <= derr;
			kp_s2   <= fast ? kp_fast_q : kp_slow_q;
			kd_s2   <= fast ? kd_fast_q : kd_slow_q;
			band_s2 <= band;
			est_s2  <= est_q;
		end
		if (adv3) begin
			pp_s3   <= $signed({1'b0, kp_s2}) * err_s2;
			pd_s3   <= $signed({1'b0, kd_s2}) * derr_s2;
			band_s3 <= band_s2;
			est_s3  <= est_s2;
		end
		if (adv4) begin
			est_s4 <= est_s3;
		end
		if (adv5) begin
			drive_s5 <= drive_x[msp_pkg::PULSE_W-1:0];
			fwd_s5   <= drive_x[msp_pkg::PULSE_W] ? '0 : drive_x[msp_pkg::LIMIT_W-1:0];
			rev_s5   <= drive_x[msp_pkg::PULSE_W] ? (-drive_x[msp_pkg::LIMIT_W-1:0]) : '0;
			est_s5   <= est_s4;
		end
	end

	assign result.valid          = v5_q;
	assign result.drive_value    = drive_s5;
	assign result.forward_duty   = fwd_s5;
	assign result.reverse_duty   = rev_s5;
	assign result.filtered_speed = est_s5;

	// checks
	assign lim_chk = $signed({2'b00, pwm_limit_q, 8'h00});

	a_acc_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		v4_q |-> (acc_q <= lim_chk) && (acc_q >= -lim_chk))
		else $error("accumulator outside the drive limit");

	a_duty_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		v5_q |-> (fwd_s5 == '0) || (rev_s5 == '0))
		else $error("forward and reverse duty both active");

	a_duty_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(v5_q && drive_s5[msp_pkg::PULSE_W-1]) |-> (fwd_s5 == '0))
		else $error("forward duty on a negative drive");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> (v1_q && v2_q && v3_q && v4_q && v5_q))
		else $error("input stalled with a free stage");

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> v1_q)
		else $error("accepted beat lost at the filter stage");

endmodule
